// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes for the sorted-insert priority queue.
package spq_pkg;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } spq_status_e;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } spq_action_e;

  // One stored entry of the chain.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] pri;
    logic        [15:0] id;
  } spq_entry_t;

  // Operation broadcast to every cell in the cycle of the transfer.
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic signed [15:0] key;
    logic        [15:0] id;
  } spq_cmd_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spq_cmd_t   cmd_i,
  input  spq_entry_t prev_entry_i,
  input  logic       prev_below_i,
  input  spq_entry_t next_entry_i,
  output spq_entry_t entry_o,
  output logic       below_o
);

  logic               valid_q, valid_d;
  logic signed [15:0] pri_q, pri_d;
  logic        [15:0] id_q, id_d;

  // The new key goes behind every entry of equal or higher priority.
  assign below_o = !valid_q || (pri_q < cmd_i.key);
  assign entry_o = '{valid: valid_q, pri: pri_q, id: id_q};

  always_comb begin
    valid_d = valid_q;
    pri_d   = pri_q;
    id_d    = id_q;
    if (cmd_i.enq) begin
      // The predecessor moving back means this entry is lower too; take its place.
      if (prev_below_i) begin
        valid_d = prev_entry_i.valid;
        pri_d   = prev_entry_i.pri;
        id_d    = prev_entry_i.id;
      end else if (below_o) begin
        valid_d = 1'b1;
        pri_d   = cmd_i.key;
        id_d    = cmd_i.id;
      end
    end else if (cmd_i.deq) begin
      valid_d = next_entry_i.valid;
      pri_d   = next_entry_i.pri;
      id_d    = next_entry_i.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    id_q  <= id_d;
  end

endmodule

// ===== rtl/core/sorted_insert_priority_queue.sv =====
// Top level of the sorted-insert priority queue built as a chain of cells.
//
// Input stream: s_axis_tuser_i carries the action (0 enqueue, 1 dequeue),
// s_axis_tdata_i carries the entry id and signed priority for an enqueue.
// Output stream: one result per input transfer; m_axis_tuser_o carries the
// status (0 enqueued, 1 full and dropped, 2 dequeued, 3 empty), m_axis_tdata_o
// the dequeued id and priority (zero otherwise) and the fill level.
// Entries sit in DEPTH cells kept in descending priority order; every cell
// compares its key with the broadcast one and all cells shift together; the
// result is registered, so it appears in the cycle after its transfer.
// One item per cycle is sustained while the receiver keeps up; the output
// register is refilled in the cycle it is taken. When the receiver stalls, the
// held result blocks new input transfers until it is taken.
// Reset clears all valid bits, the fill count and the output register; the
// queue is empty and ready right after reset.
module sorted_insert_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // item_id[15:0], item_priority[31:16]
  input  logic        s_axis_tuser_i,  // action[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // out_id[15:0], out_priority[31:16],
                                       // fill_level[36:32], zero[39:37]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  localparam int CntW = $clog2(DEPTH + 1);

  spq_entry_t entries [DEPTH];
  logic       below   [DEPTH];
  spq_cmd_t   cmd;

  logic        accept;
  logic        full, empty;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     count_ext;

  logic               out_valid_q;
  spq_status_e        status_q, status_d;
  logic        [15:0] out_id_q, out_id_d;
  logic signed [15:0] out_pri_q, out_pri_d;
  logic        [4:0]  fill_q, fill_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign full  = entries[DEPTH-1].valid;
  assign empty = !entries[0].valid;

  assign cmd.enq = accept && (s_axis_tuser_i == ACT_ENQUEUE) && !full;
  assign cmd.deq = accept && (s_axis_tuser_i == ACT_DEQUEUE) && !empty;
  assign cmd.key = $signed(s_axis_tdata_i[31:16]);
  assign cmd.id  = s_axis_tdata_i[15:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    spq_entry_t prev_entry, next_entry;
    logic       prev_below;

    if (g == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_below = 1'b0;
    end else begin : g_body
      assign prev_entry = entries[g-1];
      assign prev_below = below[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entries[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_entry_i (prev_entry),
      .prev_below_i (prev_below),
      .next_entry_i (next_entry),
      .entry_o      (entries[g]),
      .below_o      (below[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  // The reported fill level keeps the low five bits of the count.
  assign count_ext = 32'(count_d);

  always_comb begin
    out_id_d  = '0;
    out_pri_d = '0;
    fill_d    = count_ext[4:0];
    if (s_axis_tuser_i == ACT_ENQUEUE) begin
      status_d = full ? ST_FULL : ST_ENQUEUED;
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      status_d  = ST_DEQUEUED;
      out_id_d  = entries[0].id;
      out_pri_d = entries[0].pri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_ENQUEUED;
      out_id_q    <= '0;
      out_pri_q   <= '0;
      fill_q      <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        out_id_q    <= out_id_d;
        out_pri_q   <= out_pri_d;
        fill_q      <= fill_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {3'b000, fill_q, out_pri_q, out_id_q};

endmodule

// ===== tb/spq_checker.sv =====
// Checker that tracks the queue contents, predicts each result and compares it.
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // item_id[15:0], item_priority[31:16]
  input  logic        s_axis_tuser_i,   // action[0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // out_id[15:0], out_priority[31:16],
                                        // fill_level[36:32], zero[39:37]
  input  logic [1:0]  m_axis_tuser_i,   // status[1:0]
  output int          error_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        [15:0] id;
    logic signed [15:0] pri;
  } held_entry_t;

  typedef struct packed {
    spq_status_e        status;
    logic        [15:0] id;
    logic signed [15:0] pri;
    logic        [4:0]  fill;
  } queue_result_t;

  // Entries in leaving order: index 0 is the next one to be dequeued.
  held_entry_t   sorted_entries[$];
  queue_result_t pending_results[$];
  int            errors;

  function automatic queue_result_t apply_queue_op(spq_action_e act,
                                                   logic [15:0] new_id,
                                                   logic signed [15:0] new_pri);
    queue_result_t res;
    held_entry_t   ent;
    int            pos;
    res = '0;
    if (act == ACT_ENQUEUE) begin
      if (sorted_entries.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Walk up past every entry of strictly lower priority, so ties keep
        // their arrival order.
        pos = sorted_entries.size();
        while (pos > 0 && sorted_entries[pos-1].pri < new_pri) pos--;
        ent.id  = new_id;
        ent.pri = new_pri;
        sorted_entries.insert(pos, ent);
        res.status = ST_ENQUEUED;
      end
    end else if (sorted_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      ent = sorted_entries.pop_front();
      res.id     = ent.id;
      res.pri    = ent.pri;
      res.status = ST_DEQUEUED;
    end
    res.fill = 5'(sorted_entries.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t      want;
    logic        [15:0] got_id;
    logic signed [15:0] got_pri;
    logic        [4:0]  got_fill;
    if (!rst_ni) begin
      sorted_entries.delete();
      pending_results.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_id   = m_axis_tdata_i[15:0];
        got_pri  = m_axis_tdata_i[31:16];
        got_fill = m_axis_tdata_i[36:32];
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d data %h",
                   $time, m_axis_tuser_i, m_axis_tdata_i);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser_i != want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_axis_tuser_i);
          end
          if (got_id != want.id) begin
            errors++;
            $display("%0t: out_id expected %h actual %h", $time, want.id, got_id);
          end
          if (got_pri != want.pri) begin
            errors++;
            $display("%0t: out_priority expected %0d actual %0d", $time, want.pri,
                     got_pri);
          end
          if (got_fill != want.fill) begin
            errors++;
            $display("%0t: fill_level expected %0d actual %0d", $time, want.fill,
                     got_fill);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_results.push_back(apply_queue_op(spq_action_e'(s_axis_tuser_i),
                                                 s_axis_tdata_i[15:0],
                                                 s_axis_tdata_i[31:16]));
      end
      error_count_o <= errors;
      pending_o     <= pending_results.size();
    end
  end

endmodule

// ===== tb/tb_sorted_insert_priority_queue.sv =====
// Testbench top for the sorted-insert priority queue: stimulus, stalls and verdict.
module tb_sorted_insert_priority_queue;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RAND_ITEMS  = 450;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // item_id[15:0], item_priority[31:16]
  logic        s_axis_tuser = 1'b0; // action[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // out_id[15:0], out_priority[31:16],
                                    // fill_level[36:32], zero[39:37]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  int   error_count;
  int   pending_count;
  int   cycle_count = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   phase_left = 0;
  int   ready_pct = 100;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_insert_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  spq_checker #(
    .DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .error_count_o   (error_count),
    .pending_o       (pending_count)
  );

  // Receiver: phases of random readiness, plus one long hold-off on request
  // so that the output register stays full and the input backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 75;
          2: ready_pct <= 40;
          default: ready_pct <= 10;
        endcase
      end else begin
        phase_left <= phase_left - 1;
      end
      m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_op(input spq_action_e act, input logic [15:0] id,
                         input logic [15:0] pri);
    s_axis_tuser  <= act;
    s_axis_tdata  <= {pri, id};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    logic [15:0] fill_pri [16] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                   16'h0000, 16'h0005, 16'h0005, 16'h0005,
                                   16'h8000, 16'h7FFF, 16'h0064, 16'hFF9C,
                                   16'h0001, 16'h0001, 16'h0007, 16'hFFF9};
    spq_action_e act;
    logic [15:0] pri;
    int          enq_pct;
    int          burst_left;
    int          gap;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Dequeue from the empty queue, fill it with extremes and ties, overflow
    // it once, then drain a few entries.
    send_op(ACT_DEQUEUE, 16'hFFFF, 16'h8000);
    for (int i = 0; i < 16; i++) send_op(ACT_ENQUEUE, 16'(i * 16'h1111), fill_pri[i]);
    send_op(ACT_ENQUEUE, 16'hABCD, 16'h7FFF);
    for (int i = 0; i < 4; i++) send_op(ACT_DEQUEUE, 16'($urandom), 16'($urandom));

    enq_pct = 50;
    burst_left = $urandom_range(1, 20);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 90;
        endcase
      end
      if (n == HOLD_AT) begin
        hold_go <= 1'b1;
        burst_left = 40;
      end
      act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
      // Mostly a narrow key range so that ties are common.
      if ($urandom_range(0, 9) < 7) pri = 16'($urandom_range(0, 15)) - 16'd8;
      else pri = 16'($urandom);
      send_op(act, 16'($urandom), pri);
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
    end
    s_axis_tvalid <= 1'b0;

    // The pending count is registered, so it covers the last transfer only from the next edge on.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_insert_priority_queue.sv
tb/spq_checker.sv
tb/tb_sorted_insert_priority_queue.sv
